FILE: src/page_span_allocator_unit_macros.svh
// assertion helpers shared by the allocator top level
`ifndef PAGE_SPAN_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_SPAN_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSA_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("page span allocator check failed");

// next-cycle implication, checked outside reset
`define PSA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("page span allocator check failed");

`endif

FILE: src/psa_pkg.sv
package psa_pkg;

  localparam int POOL_PAGES   = 1024;
  localparam int MAX_SPAN     = 128;
  localparam int PAGE_BITS    = 13;
  localparam int PG_W         = $clog2(POOL_PAGES);
  localparam int LEN_W        = 8;
  localparam int CHUNK_LIMIT  = POOL_PAGES / MAX_SPAN;
  localparam int CHUNK_W      = $clog2(CHUNK_LIMIT + 1);
  localparam int SPAN_SHIFT   = $clog2(MAX_SPAN);
  localparam int IN_W         = 48;
  localparam int OUT_W        = 24;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_REL   = 2'd1;
  localparam logic [1:0] OP_LOOK  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_NOMAP = 2'd2;
  localparam logic [1:0] ST_INV   = 2'd3;

  // controller states, also the command seen by the datapath
  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_A_CHK   = 5'd2;
  localparam logic [4:0] S_A_SCAN  = 5'd3;
  localparam logic [4:0] S_A_POP   = 5'd4;
  localparam logic [4:0] S_A_CHUNK = 5'd5;
  localparam logic [4:0] S_A_SPLIT = 5'd6;
  localparam logic [4:0] S_A_MARK  = 5'd7;
  localparam logic [4:0] S_A_MAP   = 5'd8;
  localparam logic [4:0] S_UL_RD   = 5'd9;
  localparam logic [4:0] S_UL_WR   = 5'd10;
  localparam logic [4:0] S_PF1     = 5'd11;
  localparam logic [4:0] S_PF2     = 5'd12;
  localparam logic [4:0] S_PF3     = 5'd13;
  localparam logic [4:0] S_R_RD    = 5'd14;
  localparam logic [4:0] S_R_CHK   = 5'd15;
  localparam logic [4:0] S_P_A     = 5'd16;
  localparam logic [4:0] S_P_B     = 5'd17;
  localparam logic [4:0] S_P_C     = 5'd18;
  localparam logic [4:0] S_N_A     = 5'd19;
  localparam logic [4:0] S_N_B     = 5'd20;
  localparam logic [4:0] S_N_C     = 5'd21;
  localparam logic [4:0] S_R_PF    = 5'd22;
  localparam logic [4:0] S_L_RD    = 5'd23;
  localparam logic [4:0] S_L_B     = 5'd24;
  localparam logic [4:0] S_L_C     = 5'd25;
  localparam logic [4:0] S_RESULT  = 5'd26;

  typedef logic [4:0] cmd_t;

  typedef struct packed {
    logic            vld;
    logic [PG_W-1:0] idx;
  } ptr_t;

  typedef struct packed {
    logic clr_last;
    logic k_ok;
    logic lhv_hit;
    logic i_last;
    logic chunk_ok;
    logic split;
    logic map_last;
    logic rel_ok;
    logic s_zero;
    logic m_valid;
    logic prev_fit;
    logic next_in;
    logic next_hit;
    logic next_fit;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/psa_ctrl.sv
module psa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  input  psa_pkg::dp_status_t stat,
  output psa_pkg::cmd_t       cmd
);
  import psa_pkg::*;

  localparam logic [1:0] RET_ALLOC = 2'd0;
  localparam logic [1:0] RET_PREV  = 2'd1;
  localparam logic [1:0] RET_NEXT  = 2'd2;

  logic [4:0] state, state_next;
  logic       tp, tp_next, tn, tn_next;
  logic [1:0] ret, ret_next;
  logic [1:0] op, op_next;

  assign cmd = state;

  function automatic logic [4:0] cont(input logic a, input logic b);
    if (a) return S_P_A;
    if (b) return S_N_A;
    return S_R_PF;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      tp    <= 1'b0;
      tn    <= 1'b0;
      ret   <= RET_ALLOC;
      op    <= OP_ALLOC;
    end else begin
      state <= state_next;
      tp    <= tp_next;
      tn    <= tn_next;
      ret   <= ret_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    tp_next    = tp;
    tn_next    = tn;
    ret_next   = ret;
    op_next    = op;
    unique case (state)
      S_CLR:     if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          op_next = in_op;
          unique case (in_op)
            OP_ALLOC: state_next = S_A_CHK;
            OP_REL:   state_next = S_R_RD;
            OP_LOOK:  state_next = S_L_RD;
            default:  state_next = S_RESULT;
          endcase
        end
      end
      S_A_CHK:   state_next = stat.k_ok ? S_A_SCAN : S_RESULT;
      S_A_SCAN: begin
        if (stat.lhv_hit) state_next = S_A_POP;
        else if (stat.i_last) state_next = S_A_CHUNK;
      end
      S_A_POP: begin
        ret_next   = RET_ALLOC;
        state_next = S_UL_RD;
      end
      S_UL_RD:   state_next = S_UL_WR;
      S_UL_WR: begin
        unique case (ret)
          RET_ALLOC: state_next = S_A_SPLIT;
          RET_PREV:  state_next = S_N_A;
          default:   state_next = cont(tp, tn);
        endcase
      end
      S_A_CHUNK: state_next = stat.chunk_ok ? S_A_SPLIT : S_RESULT;
      S_A_SPLIT: state_next = stat.split ? S_PF1 : S_A_MARK;
      S_PF1:     state_next = S_PF2;
      S_PF2:     state_next = S_PF3;
      S_PF3:     state_next = (op == OP_ALLOC) ? S_A_MARK : S_RESULT;
      S_A_MARK:  state_next = S_A_MAP;
      S_A_MAP:   if (stat.map_last) state_next = S_RESULT;
      S_R_RD:    state_next = S_R_CHK;
      S_R_CHK: begin
        if (stat.rel_ok) begin
          tp_next    = 1'b1;
          tn_next    = 1'b1;
          state_next = S_P_A;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_P_A: begin
        if (!tp) begin
          state_next = S_N_A;
        end else if (stat.s_zero) begin
          tp_next    = 1'b0;
          state_next = S_N_A;
        end else begin
          state_next = S_P_B;
        end
      end
      S_P_B: begin
        if (stat.m_valid) begin
          state_next = S_P_C;
        end else begin
          tp_next    = 1'b0;
          state_next = S_N_A;
        end
      end
      S_P_C: begin
        if (stat.prev_fit) begin
          ret_next   = RET_PREV;
          state_next = S_UL_RD;
        end else begin
          tp_next    = 1'b0;
          state_next = S_N_A;
        end
      end
      S_N_A: begin
        if (!tn || !stat.next_in) begin
          tn_next    = 1'b0;
          state_next = cont(tp, 1'b0);
        end else begin
          state_next = S_N_B;
        end
      end
      S_N_B: begin
        if (stat.next_hit) begin
          state_next = S_N_C;
        end else begin
          tn_next    = 1'b0;
          state_next = cont(tp, 1'b0);
        end
      end
      S_N_C: begin
        if (stat.next_fit) begin
          ret_next   = RET_NEXT;
          state_next = S_UL_RD;
        end else begin
          tn_next    = 1'b0;
          state_next = cont(tp, 1'b0);
        end
      end
      S_R_PF:    state_next = S_PF1;
      S_L_RD:    state_next = S_L_B;
      S_L_B:     state_next = stat.m_valid ? S_L_C : S_RESULT;
      S_L_C:     state_next = S_RESULT;
      S_RESULT:  if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/psa_dp.sv
module psa_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  psa_pkg::cmd_t              cmd,
  input  logic                       in_fire,
  input  logic [psa_pkg::IN_W-1:0]   in_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [psa_pkg::OUT_W-1:0]  out_data,
  output psa_pkg::dp_status_t        stat
);
  import psa_pkg::*;

  // storage
  ptr_t             pts [POOL_PAGES];
  logic [LEN_W-1:0] sl  [POOL_PAGES];
  logic             sb  [POOL_PAGES];
  ptr_t             nxt [POOL_PAGES];
  ptr_t             prv [POOL_PAGES];
  logic [PG_W-1:0]  lh  [MAX_SPAN+1];
  logic [MAX_SPAN:0] lhv;

  ptr_t             pts_q, nxt_q, prv_q;
  logic [LEN_W-1:0] sl_q;
  logic             sb_q;
  logic [PG_W-1:0]  lh_q;

  // working registers
  logic [LEN_W-1:0]   k, i, have, n, qlen, pf_len;
  logic [PG_W-1:0]    rel, page, s, q, pf_start;
  logic [PG_W-1:0]    cnt;
  logic [CHUNK_W-1:0] chunks;
  ptr_t               h;
  logic [PG_W-1:0]    res_s;
  logic [LEN_W-1:0]   res_n;
  logic [1:0]         res_st;

  // port selects
  logic [PG_W-1:0]    pts_ra, pts_wa, sl_ra, sl_wa, nx_ra, nx_wa, pv_wa;
  ptr_t               pts_wd, nx_wd, pv_wd;
  logic               pts_we, sl_we, sb_we, nx_we, pv_we, lh_we;
  logic [LEN_W-1:0]   sl_wd, lh_wi, lh_ri;
  logic               sb_wd, lhv_wd;
  logic [PG_W-1:0]    lh_wd;
  logic [PG_W:0]      s_plus_n, q_plus_l;
  logic [LEN_W:0]     n_plus_l;

  assign s_plus_n = {1'b0, s} + {{(PG_W+1-LEN_W){1'b0}}, n};
  assign q_plus_l = {1'b0, pts_q.idx} + {{(PG_W+1-LEN_W){1'b0}}, sl_q};
  assign n_plus_l = {1'b0, n} + {1'b0, sl_q};

  always_comb begin
    stat.clr_last = (cnt == PG_W'(POOL_PAGES - 1));
    stat.k_ok     = (k != '0) && (k <= LEN_W'(MAX_SPAN));
    stat.lhv_hit  = lhv[i];
    stat.i_last   = (i == LEN_W'(MAX_SPAN));
    stat.chunk_ok = (chunks < CHUNK_W'(CHUNK_LIMIT));
    stat.split    = (have > k);
    stat.map_last = (cnt[LEN_W-1:0] == k - 1'b1);
    stat.rel_ok   = pts_q.vld && (pts_q.idx == rel) && sb_q;
    stat.s_zero   = (s == '0);
    stat.m_valid  = pts_q.vld;
    stat.prev_fit = !sb_q && (q_plus_l == {1'b0, s}) && (n_plus_l <= (LEN_W+1)'(MAX_SPAN));
    stat.next_in  = (s_plus_n < (PG_W+1)'(POOL_PAGES));
    stat.next_hit = pts_q.vld && (pts_q.idx == q);
    stat.next_fit = !sb_q && (n_plus_l <= (LEN_W+1)'(MAX_SPAN));
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    pts_ra = s - 1'b1;
    pts_we = 1'b0;
    pts_wa = pf_start;
    pts_wd = '{vld: 1'b1, idx: pf_start};
    sl_ra  = pts_q.idx;
    sl_we  = 1'b0;
    sl_wa  = pf_start;
    sl_wd  = pf_len;
    sb_we  = 1'b0;
    sb_wd  = 1'b0;
    nx_ra  = q;
    nx_we  = 1'b0;
    nx_wa  = prv_q.idx;
    nx_wd  = nxt_q;
    pv_we  = 1'b0;
    pv_wa  = nxt_q.idx;
    pv_wd  = prv_q;
    lh_ri  = i;
    lh_we  = 1'b0;
    lh_wi  = qlen;
    lh_wd  = nxt_q.idx;
    lhv_wd = nxt_q.vld;
    case (cmd)
      S_CLR: begin
        pts_we = 1'b1;
        pts_wa = cnt;
        pts_wd = '0;
      end
      S_A_MARK: begin
        sl_we = 1'b1;
        sl_wa = s;
        sl_wd = k;
        sb_we = 1'b1;
        sb_wd = 1'b1;
      end
      S_A_MAP: begin
        pts_we = 1'b1;
        pts_wa = s + cnt;
        pts_wd = '{vld: 1'b1, idx: s};
      end
      S_UL_WR: begin
        if (prv_q.vld) nx_we = 1'b1;
        else lh_we = 1'b1;
        pv_we = nxt_q.vld;
      end
      S_PF1: begin
        pts_we = 1'b1;
        sl_we  = 1'b1;
        sb_we  = 1'b1;
        lh_ri  = pf_len;
      end
      S_PF2: begin
        pts_we = 1'b1;
        pts_wa = pf_start + PG_W'(pf_len) - 1'b1;
        nx_we  = 1'b1;
        nx_wa  = pf_start;
        nx_wd  = '{vld: lhv[pf_len], idx: lh_q};
        pv_we  = 1'b1;
        pv_wa  = pf_start;
        pv_wd  = '0;
        lh_we  = 1'b1;
        lh_wi  = pf_len;
        lh_wd  = pf_start;
        lhv_wd = 1'b1;
      end
      S_PF3: begin
        pv_we = h.vld;
        pv_wa = h.idx;
        pv_wd = '{vld: 1'b1, idx: pf_start};
      end
      S_R_RD: begin
        pts_ra = rel;
        sl_ra  = rel;
      end
      S_R_CHK: begin
        sb_we = stat.rel_ok;
        sl_wa = rel;
      end
      S_N_A:   pts_ra = s_plus_n[PG_W-1:0];
      S_N_B:   sl_ra = q;
      S_L_RD:  pts_ra = page;
      default: ;
    endcase
    if (cmd == S_A_MARK || cmd == S_R_CHK) sl_wa = (cmd == S_A_MARK) ? s : rel;
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    pts_q <= pts[pts_ra];
    if (pts_we) pts[pts_wa] <= pts_wd;
  end

  always_ff @(posedge clk) begin
    sl_q <= sl[sl_ra];
    if (sl_we) sl[sl_wa] <= sl_wd;
  end

  always_ff @(posedge clk) begin
    sb_q <= sb[sl_ra];
    if (sb_we) sb[sl_wa] <= sb_wd;
  end

  always_ff @(posedge clk) begin
    nxt_q <= nxt[nx_ra];
    if (nx_we) nxt[nx_wa] <= nx_wd;
  end

  always_ff @(posedge clk) begin
    prv_q <= prv[nx_ra];
    if (pv_we) prv[pv_wa] <= pv_wd;
  end

  always_ff @(posedge clk) begin
    lh_q <= lh[lh_ri];
    if (lh_we) lh[lh_wi] <= lh_wd;
  end

  // list valid bits and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      lhv       <= '0;
      cnt       <= '0;
      chunks    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (lh_we) lhv[lh_wi] <= lhv_wd;
      case (cmd)
        S_CLR:    cnt <= cnt + 1'b1;
        S_A_MARK: cnt <= '0;
        S_A_MAP:  cnt <= cnt + 1'b1;
        S_A_CHUNK: if (stat.chunk_ok) chunks <= chunks + 1'b1;
        default: ;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd == S_RESULT && stat.out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == S_RESULT && stat.out_free) out_data <= {4'b0, res_st, res_n, res_s};
    case (cmd)
      S_IDLE: begin
        if (in_fire) begin
          k      <= in_data[9:2];
          rel    <= in_data[19:10];
          page   <= in_data[20+PAGE_BITS +: PG_W];
          res_s  <= '0;
          res_n  <= '0;
          res_st <= ST_INV;
        end
      end
      S_A_CHK:  i <= k;
      S_A_SCAN: if (!lhv[i]) i <= i + 1'b1;
      S_A_POP: begin
        s    <= lh_q;
        q    <= lh_q;
        qlen <= i;
        have <= i;
      end
      S_A_CHUNK: begin
        if (stat.chunk_ok) begin
          s    <= PG_W'(chunks) << SPAN_SHIFT;
          have <= LEN_W'(MAX_SPAN);
        end else begin
          res_st <= ST_OOM;
        end
      end
      S_A_SPLIT: begin
        pf_start <= s + PG_W'(k);
        pf_len   <= have - k;
      end
      S_A_MARK: begin
        res_s  <= s;
        res_n  <= k;
        res_st <= ST_OK;
      end
      S_PF2:    h <= '{vld: lhv[pf_len], idx: lh_q};
      S_R_CHK: begin
        s <= rel;
        n <= sl_q;
      end
      S_P_B:    q <= pts_q.idx;
      S_P_C: begin
        if (stat.prev_fit) begin
          qlen <= sl_q;
          n    <= n_plus_l[LEN_W-1:0];
          s    <= q;
        end
      end
      S_N_A:    q <= s_plus_n[PG_W-1:0];
      S_N_C: begin
        if (stat.next_fit) begin
          qlen <= sl_q;
          n    <= n_plus_l[LEN_W-1:0];
        end
      end
      S_R_PF: begin
        pf_start <= s;
        pf_len   <= n;
        res_s    <= s;
        res_n    <= n;
        res_st   <= ST_OK;
      end
      S_L_RD:   res_st <= ST_NOMAP;
      S_L_B:    s <= pts_q.idx;
      S_L_C: begin
        res_s  <= s;
        res_n  <= sl_q;
        res_st <= ST_OK;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/page_span_allocator_unit.sv
// Page-span allocator over a 1024-page pool, one request at a time. After
// reset the page map is cleared in one pass over every page before the
// first beat is taken. A request then runs on a controller that walks one
// memory step a cycle, pausing while a finished result waits for the
// output register: lookup reads the page map and the span length, allocate
// scans the size lists one per cycle, sets up the span and then maps each
// granted page, and release checks the span, merges free neighbors one at a
// time and files the merged span on its size list. The result sits in an
// output register; the next beat is taken once it is loaded there, and a
// result still waiting in that register holds off the next one.
module page_span_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, page_count, span_start_page, object_address, zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_start_page, result_page_count, status, zero pad
  output logic [23:0] m_axis_tdata
);
  import psa_pkg::*;
  `include "page_span_allocator_unit_macros.svh"

  cmd_t       cmd;
  dp_status_t stat;
  logic       in_fire;

  assign s_axis_tready = (cmd == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tdata[1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  psa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_fire   (in_fire),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .stat      (stat)
  );

  `PSA_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tdata[19:18] != ST_OK, m_axis_tdata[17:0] == '0)
  `PSA_ASSERT_NOW(a_ok_len, m_axis_tvalid && m_axis_tdata[19:18] == ST_OK, m_axis_tdata[17:10] != '0)
  `PSA_ASSERT_NEXT(a_one_req, in_fire, !s_axis_tready)

endmodule

FILE: dv/page_span_allocator_unit_tb.sv
module page_span_allocator_unit_tb;
  import psa_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [PG_W-1:0]  start_page;
    logic [LEN_W-1:0] page_count;
    logic [1:0]       status;
  } span_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  page_span_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // allocator mirror
  ptr_t             page_map [POOL_PAGES];
  logic [LEN_W-1:0] span_len [POOL_PAGES];
  logic             span_used [POOL_PAGES];
  ptr_t             free_head [MAX_SPAN+1];
  ptr_t             link_next [POOL_PAGES];
  ptr_t             link_prev [POOL_PAGES];
  int unsigned      chunk_count;

  span_result_t pending_results[$];
  int unsigned  live_spans[$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  bit           sink_stalls_on;
  int unsigned  sink_stall_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_free(int unsigned len, int unsigned s);
    ptr_t h;
    h = free_head[len];
    link_next[s] = h;
    link_prev[s] = '0;
    if (h.vld) link_prev[h.idx] = '{1'b1, PG_W'(s)};
    free_head[len] = '{1'b1, PG_W'(s)};
  endfunction

  function automatic void unlink_free(int unsigned len, int unsigned s);
    ptr_t p, n;
    p = link_prev[s];
    n = link_next[s];
    if (p.vld) link_next[p.idx] = n;
    else free_head[len] = n;
    if (n.vld) link_prev[n.idx] = p;
  endfunction

  function automatic void map_to(int unsigned page, int unsigned s);
    if (page < POOL_PAGES) page_map[page] = '{1'b1, PG_W'(s)};
  endfunction

  function automatic void park_free(int unsigned s, int unsigned len);
    if (s >= POOL_PAGES || len == 0) return;
    span_len[s] = LEN_W'(len);
    span_used[s] = 1'b0;
    map_to(s, s);
    map_to(s + len - 1, s);
    push_free(len, s);
  endfunction

  function automatic bit free_owner(int unsigned page, output int unsigned s);
    s = 0;
    if (page >= POOL_PAGES || !page_map[page].vld) return 1'b0;
    if (span_used[page_map[page].idx]) return 1'b0;
    s = page_map[page].idx;
    return 1'b1;
  endfunction

  function automatic span_result_t allocator_step(logic [1:0] op, logic [7:0] k,
                                                  logic [9:0] rel, logic [22:0] addr);
    span_result_t r;
    int unsigned s, n, q, have, page;
    bit try_prev, try_next;
    r = '{'0, '0, ST_INV};
    if (op == OP_ALLOC) begin
      if (k >= 1 && k <= MAX_SPAN) begin
        have = 0;
        s = 0;
        for (int i = k; i <= MAX_SPAN; i++) begin
          if (free_head[i].vld) begin
            s = free_head[i].idx;
            unlink_free(i, s);
            have = i;
            break;
          end
        end
        if (have == 0 && chunk_count < CHUNK_LIMIT) begin
          s = chunk_count * MAX_SPAN;
          chunk_count++;
          have = MAX_SPAN;
        end
        if (have != 0) begin
          if (have > k) park_free(s + k, have - k);
          span_len[s] = k;
          span_used[s] = 1'b1;
          for (int p = s; p < s + k; p++) map_to(p, s);
          r = '{PG_W'(s), k, ST_OK};
        end else begin
          r.status = ST_OOM;
        end
      end
    end else if (op == OP_REL) begin
      if (page_map[rel].vld && page_map[rel].idx == rel && span_used[rel]) begin
        s = rel;
        n = span_len[rel];
        try_prev = 1'b1;
        try_next = 1'b1;
        span_used[rel] = 1'b0;
        while (try_prev || try_next) begin
          if (try_prev) begin
            if (s > 0 && free_owner(s - 1, q) && q + span_len[q] == s &&
                n + span_len[q] <= MAX_SPAN) begin
              unlink_free(span_len[q], q);
              n += span_len[q];
              s = q;
            end else begin
              try_prev = 1'b0;
            end
          end
          if (try_next) begin
            if (free_owner(s + n, q) && q == s + n && n + span_len[q] <= MAX_SPAN) begin
              unlink_free(span_len[q], q);
              n += span_len[q];
            end else begin
              try_next = 1'b0;
            end
          end
        end
        park_free(s, n);
        r = '{PG_W'(s), LEN_W'(n), ST_OK};
      end
    end else if (op == OP_LOOK) begin
      page = addr >> PAGE_BITS;
      r.status = ST_NOMAP;
      if (page < POOL_PAGES && page_map[page].vld)
        r = '{page_map[page].idx, span_len[page_map[page].idx], ST_OK};
    end
    return r;
  endfunction

  task automatic send_request(logic [1:0] op, logic [7:0] k, logic [9:0] rel,
                              logic [22:0] addr);
    span_result_t r;
    s_axis_tdata <= {5'd0, addr, rel, k, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    r = allocator_step(op, k, rel, addr);
    pending_results.push_back(r);
    if (r.status == ST_OK && op == OP_ALLOC) live_spans.push_back(r.start_page);
    if (r.status == ST_OK && op == OP_REL) begin
      foreach (live_spans[i]) begin
        if (live_spans[i] == rel) begin
          live_spans.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic source_gap(bit allowed);
    if (allowed && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic release_pick();
    int unsigned i;
    i = $urandom_range(0, live_spans.size() - 1);
    send_request(OP_REL, 8'($urandom), 10'(live_spans[i]), 23'($urandom));
  endtask

  task automatic test_bad_requests();
    send_request(OP_ALLOC, 8'd0, 10'd0, 23'd0);
    send_request(OP_ALLOC, 8'd129, 10'h3ff, 23'h7fffff);
    send_request(OP_ALLOC, 8'd255, 10'd0, 23'd0);
    send_request(2'd3, 8'd1, 10'd0, 23'd0);
    send_request(OP_LOOK, 8'd0, 10'd0, 23'h7fffff);
    send_request(OP_REL, 8'd0, 10'd0, 23'd0);
  endtask

  task automatic test_chunks_and_merge();
    send_request(OP_ALLOC, 8'd1, 10'd0, 23'd0);
    send_request(OP_LOOK, 8'd0, 10'd0, 23'h1fff);
    // tail of the split chunk, only its boundaries are mapped
    send_request(OP_LOOK, 8'd0, 10'd0, 23'(127 << PAGE_BITS));
    send_request(OP_LOOK, 8'd0, 10'd0, 23'(64 << PAGE_BITS));
    send_request(OP_REL, 8'd0, 10'd1, 23'd0);
    send_request(OP_REL, 8'd0, 10'd0, 23'd0);
    send_request(OP_REL, 8'd0, 10'd0, 23'd0);
    // drain the whole pool into full-size spans, then one more fails
    repeat (CHUNK_LIMIT + 1) send_request(OP_ALLOC, 8'd128, 10'd0, 23'd0);
    send_request(OP_LOOK, 8'd0, 10'd0, 23'h7fffff);
    while (live_spans.size() > 0) release_pick();
  endtask

  task automatic test_random_traffic(int unsigned count, bit gaps);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      source_gap(gaps);
      if (n == count / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (live_spans.size() > 40 && pick < 40) pick += 40;
      if (pick < 40) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_request(OP_ALLOC, 8'($urandom_range(1, 8)), 10'($urandom),
                                    23'($urandom));
        else if (pick < 90) send_request(OP_ALLOC, 8'($urandom_range(1, 40)), 10'($urandom),
                                         23'($urandom));
        else if (pick < 95) send_request(OP_ALLOC, 8'($urandom_range(100, 128)),
                                         10'($urandom), 23'($urandom));
        else send_request(OP_ALLOC, ($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(129, 255))),
                          10'($urandom), 23'($urandom));
      end else if (pick < 75) begin
        if (live_spans.size() > 0 && $urandom_range(0, 99) < 85) release_pick();
        else send_request(OP_REL, 8'($urandom), 10'($urandom), 23'($urandom));
      end else if (pick < 95) begin
        send_request(OP_LOOK, 8'($urandom), 10'($urandom), 23'($urandom));
      end else begin
        send_request(2'd3, 8'($urandom), 10'($urandom), 23'($urandom));
      end
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall_left <= 0;
    end else if (sink_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      sink_stall_left <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    span_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[9:0], m_axis_tdata[17:10], m_axis_tdata[19:18]};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.start_page !== want.start_page || got.page_count !== want.page_count ||
            got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected start %0d count %0d status %0d, got %0d %0d %0d",
                     want.start_page, want.page_count, want.status,
                     got.start_page, got.page_count, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    for (int i = 0; i < POOL_PAGES; i++) page_map[i] = '0;
    for (int i = 0; i <= MAX_SPAN; i++) free_head[i] = '0;
    chunk_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    sink_stalls_on = 1'b1;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_bad_requests();
    test_chunks_and_merge();
    test_random_traffic(1200, 1'b1);
    sink_stalls_on = 1'b0;
    test_random_traffic(220, 1'b0);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
